// ===== hw/rtl/b64lw_pkg.sv =====
`timescale 1ns / 1ps

package b64lw_pkg;

    // Character codes
    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [7:0] LF_CHAR  = 8'h0a;

    // Register reset value
    localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;

    // Symbol field mask
    localparam logic [5:0] SYM_MASK = 6'h3f;

    // Position in the three-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // Queue depth
    localparam int QUEUE_DEPTH = 2;

    // One classified input byte: up to two symbols, then pads
    typedef struct packed {
        logic [2:0][5:0] sym;
        logic [1:0]      nsym;
        logic [1:0]      npad;
        logic            last;
    } job_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    // Six-bit value to standard alphabet character
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v & SYM_MASK};
            if (w < 8'd26)
            begin
                c = w + 8'd65;
            end
            else if (w < 8'd52)
            begin
                c = w + 8'd71;
            end
            else if (w < 8'd62)
            begin
                c = w - 8'd4;
            end
            else if (w == 8'd62)
            begin
                c = 8'h2b;
            end
            else
            begin
                c = 8'h2f;
            end
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/b64lw_front.sv =====
`timescale 1ns / 1ps

module b64lw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               full,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               push,
    output b64lw_pkg::job_t    job
);

    logic [1:0] group_phase_reg;
    logic [1:0] group_phase_next;
    logic [3:0] bit_residue_reg;
    logic [3:0] bit_residue_next;

    assign push = in_valid && !full;

    // Split the byte into symbols by group position
    always_comb
    begin
        job              = '0;
        job.last         = in_last;
        group_phase_next = group_phase_reg;
        bit_residue_next = bit_residue_reg;
        case (group_phase_reg)
            b64lw_pkg::PHASE_1:
            begin
                job.sym[0]       = {bit_residue_reg[1:0], in_byte[7:4]};
                job.nsym         = 2'd1;
                bit_residue_next = in_byte[3:0];
                group_phase_next = b64lw_pkg::PHASE_2;
                if (in_last)
                begin
                    job.sym[1] = {in_byte[3:0], 2'b00};
                    job.nsym   = 2'd2;
                    job.npad   = 2'd1;
                end
            end
            b64lw_pkg::PHASE_2:
            begin
                job.sym[0]       = {bit_residue_reg, in_byte[7:6]};
                job.sym[1]       = in_byte[5:0];
                job.nsym         = 2'd2;
                bit_residue_next = 4'd0;
                group_phase_next = b64lw_pkg::PHASE_0;
            end
            default:
            begin
                job.sym[0]       = in_byte[7:2];
                job.nsym         = 2'd1;
                bit_residue_next = {2'b00, in_byte[1:0]};
                group_phase_next = b64lw_pkg::PHASE_1;
                if (in_last)
                begin
                    job.sym[1] = {in_byte[1:0], 4'b0000};
                    job.nsym   = 2'd2;
                    job.npad   = 2'd2;
                end
            end
        endcase
        // Final byte returns the group state to reset
        if (in_last)
        begin
            group_phase_next = b64lw_pkg::PHASE_0;
            bit_residue_next = 4'd0;
        end
    end

    // Group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_phase_reg <= b64lw_pkg::PHASE_0;
            bit_residue_reg <= 4'd0;
        end
        else if (push)
        begin
            group_phase_reg <= group_phase_next;
            bit_residue_reg <= bit_residue_next;
        end
    end

endmodule

// ===== hw/rtl/b64lw_queue.sv =====
`timescale 1ns / 1ps

module b64lw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64lw_pkg::job_t    push_job,
    input  logic               pop,
    output logic               full,
    output b64lw_pkg::head_t   head
);

    localparam int PtrW = $clog2(b64lw_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(b64lw_pkg::QUEUE_DEPTH + 1);

    b64lw_pkg::job_t entry_reg [b64lw_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full       = (count_reg == CntW'(b64lw_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/b64lw_back.sv =====
`timescale 1ns / 1ps

module b64lw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  b64lw_pkg::head_t   head,
    input  logic [7:0]         line_length,
    input  logic               out_stall,
    output logic               pop,
    output logic               out_valid,
    output logic [7:0]         out_char,
    output logic               out_last
);

    logic [1:0] sym_idx_reg;
    logic [1:0] sym_idx_next;
    logic [1:0] pad_idx_reg;
    logic [1:0] pad_idx_next;
    logic       pad_mode_reg;
    logic       pad_mode_next;
    logic [7:0] column_reg;
    logic [7:0] column_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [7:0] char_next;
    logic       out_last_reg;
    logic       last_next;
    logic       load;
    logic       fire;
    logic       done;
    logic       wrap;
    logic       final_sym;
    logic       final_pad;

    assign load = !out_valid_reg || !out_stall;
    assign fire = load && head.valid;
    assign pop  = fire && done;
    assign wrap = (line_length != 8'd0) && (column_reg >= line_length);

    assign final_sym = (sym_idx_reg + 2'd1) == head.job.nsym;
    assign final_pad = (pad_idx_reg + 2'd1) == head.job.npad;

    // Pick the next character of the head job
    always_comb
    begin
        sym_idx_next  = sym_idx_reg;
        pad_idx_next  = pad_idx_reg;
        pad_mode_next = pad_mode_reg;
        column_next   = column_reg;
        char_next     = b64lw_pkg::LF_CHAR;
        last_next     = 1'b0;
        done          = 1'b0;
        if (pad_mode_reg)
        begin
            char_next    = b64lw_pkg::PAD_CHAR;
            last_next    = final_pad && head.job.last;
            done         = final_pad;
            pad_idx_next = pad_idx_reg + 2'd1;
        end
        else if (wrap)
        begin
            column_next = 8'd0;
        end
        else
        begin
            char_next = b64lw_pkg::sym_char(head.job.sym[sym_idx_reg]);
            if (column_reg != 8'hff)
            begin
                column_next = column_reg + 8'd1;
            end
            if (final_sym)
            begin
                if (head.job.npad == 2'd0)
                begin
                    done      = 1'b1;
                    last_next = head.job.last;
                end
                else
                begin
                    pad_mode_next = 1'b1;
                    pad_idx_next  = 2'd0;
                end
            end
            else
            begin
                sym_idx_next = sym_idx_reg + 2'd1;
            end
        end
        // Job finished: rewind, and reset the line column after the final byte
        if (done)
        begin
            sym_idx_next  = 2'd0;
            pad_idx_next  = 2'd0;
            pad_mode_next = 1'b0;
            if (head.job.last)
            begin
                column_next = 8'd0;
            end
        end
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_idx_reg   <= 2'd0;
            pad_idx_reg   <= 2'd0;
            pad_mode_reg  <= 1'b0;
            column_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= head.valid;
            end
            if (fire)
            begin
                sym_idx_reg  <= sym_idx_next;
                pad_idx_reg  <= pad_idx_next;
                pad_mode_reg <= pad_mode_next;
                column_reg   <= column_next;
                out_char_reg <= char_next;
                out_last_reg <= last_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/base64_encoder_line_wrap.sv =====
// The first character of a byte passes through the job queue and then the output register.
// Throughput: one output character per cycle while out_stall is low; a byte yields one or two symbols,
// up to two pads and line feeds.
// A two-entry job queue lets the input side run ahead of the character sequencer.
// Reset (rst_n low, asynchronous) clears group state, line column and queue,
// and sets line_length to 76.
`timescale 1ns / 1ps

module base64_encoder_line_wrap (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last
);

    logic               full;
    logic               push;
    logic               pop;
    b64lw_pkg::job_t    push_job;
    b64lw_pkg::head_t   head;
    logic [7:0]         line_length_reg;

    assign in_stall = full;

    // Line length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= b64lw_pkg::LINE_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_length_reg <= cfg_wr_data;
        end
    end

    b64lw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .job      (push_job)
    );

    b64lw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .line_length (line_length_reg),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .out_last    (out_last)
    );

`ifndef NO_ASSERTIONS
    // A line feed never ends the message
    a_lf_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_char == b64lw_pkg::LF_CHAR) |-> !out_last)
        else $error("line feed flagged as final character");

    // A symbol always follows a line feed directly
    a_lf_then_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_char == b64lw_pkg::LF_CHAR)
        |=> (out_valid && out_char != b64lw_pkg::LF_CHAR))
        else $error("line feed not followed by a symbol");

    // A pad that is not final is followed at once by another pad
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_char == b64lw_pkg::PAD_CHAR && !out_last)
        |=> (out_valid && out_char == b64lw_pkg::PAD_CHAR))
        else $error("pad run broken");
`endif

endmodule
